// File: design/tmeu_pkg.sv
package tmeu_pkg;

  localparam int TapeDepthDefault = 32768;
  localparam int CellBitsDefault = 8;

  localparam logic [3:0] OP_LOOPBEGIN = 4'd0;
  localparam logic [3:0] OP_LOOPEND = 4'd1;
  localparam logic [3:0] OP_ADD = 4'd2;
  localparam logic [3:0] OP_MOVE = 4'd3;
  localparam logic [3:0] OP_OUTPUT = 4'd4;
  localparam logic [3:0] OP_INPUT = 4'd5;
  localparam logic [3:0] OP_MULADD_DIV = 4'd6;
  localparam logic [3:0] OP_MULADD = 4'd7;
  localparam logic [3:0] OP_CLEAR = 4'd8;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_OPCODE = 2'd1;
  localparam logic [1:0] FAULT_ZERO_DIV = 2'd2;

  // classified instruction handed from front to back
  typedef struct packed {
    logic [3:0] opcode;
    logic [15:0] amount;
    logic [15:0] factor;
    logic [15:0] divisor;
    logic [7:0] in_byte;
    logic in_eof;
    logic [1:0] fault;
  } instr_t;

  typedef struct packed {
    logic take_branch;
    logic out_valid;
    logic [7:0] out_byte;
    logic [1:0] fault;
  } result_t;

endpackage

// File: design/tmeu_front.sv
module tmeu_front (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [63:0] s_tdata,
  output logic q_valid,
  input  logic q_ready,
  output tmeu_pkg::instr_t q_data
);
  import tmeu_pkg::*;

  instr_t fifo [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  instr_t decoded;
  logic push;
  logic pop;

  always_comb begin
    decoded.opcode = s_tdata[3:0];
    decoded.amount = s_tdata[19:4];
    decoded.factor = s_tdata[35:20];
    decoded.divisor = s_tdata[51:36];
    decoded.in_byte = s_tdata[59:52];
    decoded.in_eof = s_tdata[60];
    if (decoded.opcode > OP_CLEAR) begin
      decoded.fault = FAULT_OPCODE;
    end else if (decoded.opcode == OP_MULADD_DIV && decoded.divisor == 16'd0) begin
      decoded.fault = FAULT_ZERO_DIV;
    end else begin
      decoded.fault = FAULT_NONE;
    end
  end

  assign s_tready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data = fifo[rd_ptr];
  assign push = s_tvalid && s_tready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= decoded;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("queue overflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1) else $error("count step");
  a_bad_op_fault: assert property (@(posedge clk) disable iff (rst)
    push && s_tdata[3:0] > OP_CLEAR |-> decoded.fault == FAULT_OPCODE)
    else $error("fault class");
`endif
endmodule

// File: design/tmeu_div.sv
module tmeu_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [47:0] dividend,
  input  logic [15:0] divisor,
  output logic done,
  output logic [47:0] quotient
);
  import tmeu_pkg::*;

  // restoring division of magnitudes, one quotient bit per cycle
  logic [47:0] quo;
  logic [16:0] rem;
  logic [15:0] dsr;
  logic [5:0] cnt;
  logic busy;
  logic [16:0] trial;

  assign trial = {rem[15:0], quo[47]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo <= dividend;
        rem <= 17'd0;
        dsr <= divisor;
        cnt <= 6'd47;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= trial - {1'b0, dsr};
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[46:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: design/tmeu_back.sv
module tmeu_back #(
  parameter int TAPE_DEPTH = tmeu_pkg::TapeDepthDefault,
  parameter int CELL_BITS = tmeu_pkg::CellBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  tmeu_pkg::instr_t q_data,
  output logic m_tvalid,
  input  logic m_tready,
  output tmeu_pkg::result_t m_result
);
  import tmeu_pkg::*;

  localparam int AW = $clog2(TAPE_DEPTH);
  localparam int PW = CELL_BITS + 17;

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD = 4'd2;
  localparam logic [3:0] S_CUR = 4'd3;
  localparam logic [3:0] S_MUL = 4'd4;
  localparam logic [3:0] S_DIV = 4'd5;
  localparam logic [3:0] S_TRD = 4'd6;
  localparam logic [3:0] S_TWR = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;

  logic [CELL_BITS-1:0] tape [TAPE_DEPTH];
  logic [CELL_BITS-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [CELL_BITS-1:0] wr_data;
  logic wr_en;

  logic [3:0] state;
  logic [AW:0] clr_cnt;
  logic [AW-1:0] head;
  logic [AW-1:0] target;
  instr_t ins;
  logic [CELL_BITS-1:0] cur;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_now;
  logic signed [47:0] addend;
  logic div_start;
  logic div_done;
  logic [47:0] div_mag;
  logic [47:0] div_quo;
  logic prod_neg;

  always_ff @(posedge clk) begin
    if (wr_en) tape[wr_addr] <= wr_data;
    rd_data <= tape[rd_addr];
  end

  assign q_ready = (state == S_IDLE) && !m_tvalid;
  assign prod_neg = prod[PW-1];
  // the divider loads in the multiply cycle, so it takes the product directly
  assign prod_now = $signed(ins.factor) * $signed({1'b0, cur});
  assign div_mag = prod_now[PW-1] ? 48'(-prod_now) : 48'(prod_now);

  tmeu_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_mag),
    .divisor(ins.divisor), .done(div_done), .quotient(div_quo)
  );

  always_comb begin
    rd_addr = (state == S_TRD) ? target : head;
    wr_en = 1'b0;
    wr_addr = head;
    wr_data = '0;
    div_start = 1'b0;
    if (state == S_CLR) begin
      wr_en = 1'b1;
      wr_addr = clr_cnt[AW-1:0];
    end else if (state == S_CUR) begin
      case (ins.opcode)
        OP_ADD: begin
          wr_en = 1'b1;
          wr_data = rd_data + CELL_BITS'({{32{ins.amount[15]}}, ins.amount});
        end
        OP_INPUT: begin
          wr_en = !ins.in_eof;
          wr_data = CELL_BITS'(ins.in_byte);
        end
        OP_CLEAR: wr_en = 1'b1;
        default: wr_en = 1'b0;
      endcase
    end else if (state == S_TWR) begin
      wr_en = 1'b1;
      wr_addr = target;
      wr_data = rd_data + CELL_BITS'(addend);
    end
    if (state == S_MUL && ins.opcode == OP_MULADD_DIV) div_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      head <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(TAPE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid && q_ready) begin
            ins <= q_data;
            state <= S_RD;
          end
        end
        S_RD: state <= S_CUR;
        S_CUR: begin
          cur <= rd_data;
          m_result.take_branch <= 1'b0;
          m_result.out_valid <= 1'b0;
          m_result.out_byte <= '0;
          m_result.fault <= ins.fault;
          target <= head + AW'({{32{ins.amount[15]}}, ins.amount});
          state <= S_OUT;
          if (ins.fault == FAULT_NONE) begin
            case (ins.opcode)
              OP_LOOPBEGIN: m_result.take_branch <= (rd_data == '0);
              OP_LOOPEND: m_result.take_branch <= (rd_data != '0);
              OP_MOVE: head <= head + AW'({{32{ins.amount[15]}}, ins.amount});
              OP_OUTPUT: begin
                m_result.out_valid <= 1'b1;
                m_result.out_byte <= 8'(rd_data);
              end
              OP_MULADD, OP_MULADD_DIV: state <= S_MUL;
              default: state <= S_OUT;
            endcase
          end
        end
        S_MUL: begin
          prod <= prod_now;
          state <= (ins.opcode == OP_MULADD_DIV) ? S_DIV : S_TRD;
          addend <= 48'(prod_now);
        end
        S_DIV: begin
          if (div_done) begin
            addend <= prod_neg ? -$signed(div_quo) : $signed(div_quo);
            state <= S_TRD;
          end
        end
        S_TRD: state <= S_TWR;
        S_TWR: state <= S_OUT;
        S_OUT: begin
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |-> state == S_IDLE) else $error("accept outside idle");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |=> m_tvalid) else $error("result not raised");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !wr_en) else $error("stray tape write");
`endif
endmodule

// File: design/tape_machine_execute_unit_core.sv
// execute unit for a tape-language machine with multiply loops
// input channel s_*: one decoded instruction per item; tdata carries opcode,
// amount, factor, divisor, in_byte, in_eof from the lowest bit up
// output channel m_*: exactly one result item per instruction with
// take_branch, out_valid, out_byte, fault from the lowest bit up
// a two-entry queue sits between the decode front and the execute back, so
// the front keeps taking items until the queue is full while the back works
// or the receiver stalls; plain ops pass through tape read, a cell write where
// the op has one, and result register; muladd adds a multiply and a read and
// write of the target cell, and muladd_div also waits on the one-bit-per-cycle
// divider over a 48-bit product; the back end takes a new item only once it
// is idle and its last result has been taken
// after rst the back end clears the tape, one cell per cycle over all
// TAPE_DEPTH cells, before it executes; the queue may fill during that time
// when m_tready is low the result is held and the back end waits
module tape_machine_execute_unit_core #(
  parameter int TAPE_DEPTH = tmeu_pkg::TapeDepthDefault,
  parameter int CELL_BITS = tmeu_pkg::CellBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [63:0] s_tdata, // opcode, amount, factor, divisor, in_byte, in_eof
  output logic m_tvalid,
  input  logic m_tready,
  output logic [15:0] m_tdata  // take_branch, out_valid, out_byte, fault
);
  import tmeu_pkg::*;

  logic q_valid;
  logic q_ready;
  instr_t q_data;
  result_t res;

  tmeu_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  tmeu_back #(.TAPE_DEPTH(TAPE_DEPTH), .CELL_BITS(CELL_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_result(res)
  );

  assign m_tdata = {4'd0, res.fault, res.out_byte, res.out_valid, res.take_branch};
endmodule
